FILE: rtl/stt_pkg.sv
// Shared types, codes and character helpers for the source text tokenizer.
package stt_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int LINE_BITS_DEFAULT     = 20;

   localparam int KIND_BITS   = 5;
   localparam int START_BITS  = 32;
   localparam int LENGTH_BITS = 32;
   localparam int LINE_OUT_BITS = 20;
   localparam int MATCH_BITS  = 4;

   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int READY_LIMIT      = QUEUE_DEPTH - 2;

   localparam logic [KIND_BITS-1:0] KIND_INT     = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_FLOAT   = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_ID      = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_BOOL    = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_STRING  = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_COMMENT = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_SEMI    = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_COMMA   = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_PLUS    = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_MINUS   = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_SLASH   = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_STAR    = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_EOF     = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_UNTERM  = 5'd19;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_QUOTE   = 8'h22;
   localparam logic [7:0] CHAR_HASH    = 8'h23;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_E = 8'h65;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_LOWER_L = 8'h6C;
   localparam logic [7:0] CHAR_LOWER_R = 8'h72;
   localparam logic [7:0] CHAR_LOWER_S = 8'h73;
   localparam logic [7:0] CHAR_LOWER_T = 8'h74;
   localparam logic [7:0] CHAR_LOWER_U = 8'h75;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;

   localparam logic [MATCH_BITS-1:0] MATCH_NONE  = 4'd0;
   localparam logic [MATCH_BITS-1:0] MATCH_T     = 4'd1;
   localparam logic [MATCH_BITS-1:0] MATCH_TR    = 4'd2;
   localparam logic [MATCH_BITS-1:0] MATCH_TRU   = 4'd3;
   localparam logic [MATCH_BITS-1:0] MATCH_TRUE  = 4'd4;
   localparam logic [MATCH_BITS-1:0] MATCH_F     = 4'd5;
   localparam logic [MATCH_BITS-1:0] MATCH_FA    = 4'd6;
   localparam logic [MATCH_BITS-1:0] MATCH_FAL   = 4'd7;
   localparam logic [MATCH_BITS-1:0] MATCH_FALS  = 4'd8;
   localparam logic [MATCH_BITS-1:0] MATCH_FALSE = 4'd9;

   typedef enum logic [4:0] {
      MODE_IDLE    = 5'b00001,
      MODE_NUMBER  = 5'b00010,
      MODE_IDENT   = 5'b00100,
      MODE_STRING  = 5'b01000,
      MODE_COMMENT = 5'b10000
   } mode_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]     token_kind;
      logic [START_BITS-1:0]    value_start;
      logic [LENGTH_BITS-1:0]   value_length;
      logic [LINE_OUT_BITS-1:0] line_number;
      logic                     last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type first;
      rsp_word_type second;
   } push_type;

   typedef struct packed {
      logic                 hit;
      logic [KIND_BITS-1:0] kind;
   } op_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
             ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z));
   endfunction

   function automatic op_type op_lookup(input logic [7:0] c);
      op_type r;
      r.hit = 1'b1;
      case (c)
         CHAR_EQUAL:  r.kind = KIND_ASSIGN;
         CHAR_SEMI:   r.kind = KIND_SEMI;
         CHAR_LPAREN: r.kind = KIND_LPAREN;
         CHAR_RPAREN: r.kind = KIND_RPAREN;
         CHAR_LBRACE: r.kind = KIND_LBRACE;
         CHAR_RBRACE: r.kind = KIND_RBRACE;
         CHAR_COMMA:  r.kind = KIND_COMMA;
         CHAR_PLUS:   r.kind = KIND_PLUS;
         CHAR_MINUS:  r.kind = KIND_MINUS;
         CHAR_SLASH:  r.kind = KIND_SLASH;
         CHAR_STAR:   r.kind = KIND_STAR;
         default: begin
            r.hit  = 1'b0;
            r.kind = KIND_UNKNOWN;
         end
      endcase
      return r;
   endfunction

   function automatic logic [MATCH_BITS-1:0] next_match(input logic [MATCH_BITS-1:0] m,
                                                        input logic [7:0] c);
      logic [MATCH_BITS-1:0] r;
      r = MATCH_NONE;
      case (m)
         MATCH_T:    if (c == CHAR_LOWER_R) r = MATCH_TR;
         MATCH_TR:   if (c == CHAR_LOWER_U) r = MATCH_TRU;
         MATCH_TRU:  if (c == CHAR_LOWER_E) r = MATCH_TRUE;
         MATCH_F:    if (c == CHAR_LOWER_A) r = MATCH_FA;
         MATCH_FA:   if (c == CHAR_LOWER_L) r = MATCH_FAL;
         MATCH_FAL:  if (c == CHAR_LOWER_S) r = MATCH_FALS;
         MATCH_FALS: if (c == CHAR_LOWER_E) r = MATCH_FALSE;
         default:    r = MATCH_NONE;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/stt_if.sv
// Valid/ready channel interfaces for text bytes and token words.
interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [31:0] value_start;
   logic [31:0] value_length;
   logic [19:0] line_number;
   logic        last_of_run;

   modport source (output valid, output token_kind, output value_start,
                   output value_length, output line_number, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input value_start,
                 input value_length, input line_number, input last_of_run,
                 output ready);
endinterface

FILE: rtl/stt_scan.sv
// Input register, scanner state and per-byte token decode.
module stt_scan #(
   parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT,
   parameter int LINE_BITS     = stt_pkg::LINE_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        char_code,
   input  logic              end_of_text,
   output stt_pkg::push_type push
);

   logic                               stage_valid_ff;
   logic [7:0]                         char_ff;
   logic                               eot_ff;
   stt_pkg::mode_type                  mode_ff, mode_in;
   logic [POSITION_BITS-1:0]           pos_ff, pos_in;
   logic [LINE_BITS-1:0]               line_ff, line_in;
   logic [POSITION_BITS-1:0]           start_ff, start_in;
   logic [stt_pkg::LENGTH_BITS-1:0]    length_ff, length_in;
   logic                               dot_ff, dot_in;
   logic [stt_pkg::MATCH_BITS-1:0]     match_ff, match_in;

   logic [stt_pkg::START_BITS-1:0]     pos_out, start_out;
   logic [stt_pkg::LINE_OUT_BITS-1:0]  line_out;
   logic [stt_pkg::LENGTH_BITS-1:0]    length_grow;
   logic [stt_pkg::KIND_BITS-1:0]      flush_kind;
   stt_pkg::rsp_word_type              flush_word, a_word, b_word;
   logic                               a_valid, b_valid, done;
   stt_pkg::op_type                    op;

   if (POSITION_BITS >= stt_pkg::START_BITS) begin : g_pos_cut
      assign pos_out   = pos_ff[stt_pkg::START_BITS-1:0];
      assign start_out = start_ff[stt_pkg::START_BITS-1:0];
   end else begin : g_pos_ext
      assign pos_out   = {{(stt_pkg::START_BITS-POSITION_BITS){1'b0}}, pos_ff};
      assign start_out = {{(stt_pkg::START_BITS-POSITION_BITS){1'b0}}, start_ff};
   end

   if (LINE_BITS >= stt_pkg::LINE_OUT_BITS) begin : g_line_cut
      assign line_out = line_ff[stt_pkg::LINE_OUT_BITS-1:0];
   end else begin : g_line_ext
      assign line_out = {{(stt_pkg::LINE_OUT_BITS-LINE_BITS){1'b0}}, line_ff};
   end

   assign length_grow = (length_ff == '1) ? length_ff : length_ff + 1'b1;
   assign op          = stt_pkg::op_lookup(char_ff);

   always_comb begin
      case (mode_ff)
         stt_pkg::MODE_NUMBER:  flush_kind = dot_ff ? stt_pkg::KIND_FLOAT : stt_pkg::KIND_INT;
         stt_pkg::MODE_IDENT:   flush_kind = (match_ff == stt_pkg::MATCH_TRUE ||
                                              match_ff == stt_pkg::MATCH_FALSE) ?
                                             stt_pkg::KIND_BOOL : stt_pkg::KIND_ID;
         stt_pkg::MODE_STRING:  flush_kind = stt_pkg::KIND_UNTERM;
         stt_pkg::MODE_COMMENT: flush_kind = stt_pkg::KIND_COMMENT;
         default:               flush_kind = stt_pkg::KIND_UNKNOWN;
      endcase
      flush_word = '{flush_kind, start_out, length_ff, line_out, 1'b0};
   end

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      start_in  = start_ff;
      length_in = length_ff;
      dot_in    = dot_ff;
      match_in  = match_ff;
      a_valid   = 1'b0;
      b_valid   = 1'b0;
      a_word    = flush_word;
      b_word    = flush_word;
      done      = 1'b0;
      if (stage_valid_ff) begin
         if (eot_ff) begin
            a_valid   = (mode_ff != stt_pkg::MODE_IDLE);
            b_valid   = 1'b1;
            b_word    = '{stt_pkg::KIND_EOF, pos_out, '0, line_out, 1'b0};
            mode_in   = stt_pkg::MODE_IDLE;
            pos_in    = '0;
            line_in   = LINE_BITS'(1);
            start_in  = '0;
            length_in = '0;
            dot_in    = 1'b0;
            match_in  = stt_pkg::MATCH_NONE;
         end else begin
            pos_in = pos_ff + 1'b1;
            case (mode_ff)
               stt_pkg::MODE_NUMBER: begin
                  if (stt_pkg::is_digit(char_ff) || char_ff == stt_pkg::CHAR_DOT) begin
                     dot_in    = dot_ff | (char_ff == stt_pkg::CHAR_DOT);
                     length_in = length_grow;
                     done      = 1'b1;
                  end
               end
               stt_pkg::MODE_IDENT: begin
                  if (stt_pkg::is_alnum(char_ff)) begin
                     match_in  = stt_pkg::next_match(match_ff, char_ff);
                     length_in = length_grow;
                     done      = 1'b1;
                  end
               end
               stt_pkg::MODE_STRING: begin
                  done = 1'b1;
                  if (char_ff == stt_pkg::CHAR_QUOTE) begin
                     a_valid = 1'b1;
                     a_word.token_kind = stt_pkg::KIND_STRING;
                     mode_in = stt_pkg::MODE_IDLE;
                  end else begin
                     length_in = length_grow;
                  end
               end
               stt_pkg::MODE_COMMENT: begin
                  if (char_ff != stt_pkg::CHAR_NEWLINE) begin
                     length_in = length_grow;
                     done      = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (!done) begin
               a_valid = (mode_ff != stt_pkg::MODE_IDLE);
               mode_in = stt_pkg::MODE_IDLE;
               if (char_ff == stt_pkg::CHAR_SPACE) begin
               end else if (char_ff == stt_pkg::CHAR_NEWLINE) begin
                  if (line_ff != '1) line_in = line_ff + 1'b1;
               end else begin
                  start_in  = pos_ff;
                  length_in = stt_pkg::LENGTH_BITS'(1);
                  dot_in    = 1'b0;
                  match_in  = stt_pkg::MATCH_NONE;
                  if (stt_pkg::is_digit(char_ff)) begin
                     mode_in = stt_pkg::MODE_NUMBER;
                  end else if (stt_pkg::is_alnum(char_ff)) begin
                     mode_in  = stt_pkg::MODE_IDENT;
                     match_in = (char_ff == stt_pkg::CHAR_LOWER_T) ? stt_pkg::MATCH_T :
                                (char_ff == stt_pkg::CHAR_LOWER_F) ? stt_pkg::MATCH_F :
                                stt_pkg::MATCH_NONE;
                  end else if (char_ff == stt_pkg::CHAR_QUOTE) begin
                     mode_in   = stt_pkg::MODE_STRING;
                     start_in  = pos_ff + 1'b1;
                     length_in = '0;
                  end else if (char_ff == stt_pkg::CHAR_HASH) begin
                     mode_in = stt_pkg::MODE_COMMENT;
                  end else begin
                     b_valid = 1'b1;
                     b_word  = '{op.kind, pos_out, stt_pkg::LENGTH_BITS'(1), line_out, 1'b0};
                  end
               end
            end
         end
      end
   end

   always_comb begin
      push.count  = {1'b0, a_valid} + {1'b0, b_valid};
      push.first  = a_valid ? a_word : b_word;
      push.second = b_word;
      push.first.last_of_run  = !(a_valid && b_valid);
      push.second.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      char_ff <= char_code;
      eot_ff  <= end_of_text;
      if (reset) begin
         stage_valid_ff <= 1'b0;
         mode_ff        <= stt_pkg::MODE_IDLE;
         pos_ff         <= '0;
         line_ff        <= LINE_BITS'(1);
         start_ff       <= '0;
         length_ff      <= '0;
         dot_ff         <= 1'b0;
         match_ff       <= stt_pkg::MATCH_NONE;
      end else begin
         stage_valid_ff <= take;
         mode_ff        <= mode_in;
         pos_ff         <= pos_in;
         line_ff        <= line_in;
         start_ff       <= start_in;
         length_ff      <= length_in;
         dot_ff         <= dot_in;
         match_ff       <= match_in;
      end
   end

endmodule

FILE: rtl/stt_queue.sv
// Four-word result queue taking up to two token words per cycle.
module stt_queue (
   input  logic                                   clock,
   input  logic                                   reset,
   input  stt_pkg::push_type                      push,
   input  logic                                   pop,
   output stt_pkg::rsp_word_type                  head,
   output logic                                   head_valid,
   output logic [stt_pkg::QUEUE_COUNT_BITS-1:0]   count
);

   stt_pkg::rsp_word_type                  entry_ff [stt_pkg::QUEUE_DEPTH];
   logic [stt_pkg::QUEUE_PTR_BITS-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [stt_pkg::QUEUE_COUNT_BITS-1:0]   count_ff, count_in;
   logic [stt_pkg::QUEUE_PTR_BITS-1:0]     wr_next;

   assign head       = entry_ff[rd_ff];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;
   assign wr_next    = wr_ff + 1'b1;

   always_comb begin
      wr_in    = wr_ff + stt_pkg::QUEUE_PTR_BITS'(push.count);
      rd_in    = rd_ff + stt_pkg::QUEUE_PTR_BITS'(pop);
      count_in = count_ff + stt_pkg::QUEUE_COUNT_BITS'(push.count)
                 - stt_pkg::QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_next] <= push.second;
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/source_text_tokenizer.sv
// Streaming source text tokenizer: one text byte per word, token words out.
// Flow: a byte is registered at acceptance and decoded into the result queue the next
// cycle, where its first word is offered at the queue head.
// Throughput: one byte per cycle while queued plus decoding words stay within two; a byte
// ending a token that is itself an operator or unknown, or end of text, can give two words.
// Reset: synchronous; clears the scanner to idle, position 0, line 1, queue empty.
module source_text_tokenizer #(
   parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEFAULT,
   parameter int LINE_BITS     = stt_pkg::LINE_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   stt_req_if.sink   req_channel,
   stt_rsp_if.source rsp_channel
);

   stt_pkg::push_type                      push;
   stt_pkg::rsp_word_type                  head;
   logic                                   head_valid;
   logic [stt_pkg::QUEUE_COUNT_BITS-1:0]   count;
   logic                                   take, pop;

   assign req_channel.ready = (stt_pkg::QUEUE_COUNT_BITS'(count + push.count) <=
                               stt_pkg::QUEUE_COUNT_BITS'(stt_pkg::READY_LIMIT)) && !reset;
   assign take = req_channel.valid && req_channel.ready;
   assign pop  = rsp_channel.valid && rsp_channel.ready;

   stt_scan #(
      .POSITION_BITS(POSITION_BITS),
      .LINE_BITS    (LINE_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .char_code  (req_channel.char_code),
      .end_of_text(req_channel.end_of_text),
      .push       (push)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .head_valid(head_valid),
      .count     (count)
   );

   assign rsp_channel.valid        = head_valid;
   assign rsp_channel.token_kind   = head.token_kind;
   assign rsp_channel.value_start  = head.value_start;
   assign rsp_channel.value_length = head.value_length;
   assign rsp_channel.line_number  = head.line_number;
   assign rsp_channel.last_of_run  = head.last_of_run;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count <= stt_pkg::QUEUE_COUNT_BITS'(stt_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_pair_marks: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> (!push.first.last_of_run && push.second.last_of_run))
      else $error("two-word push with wrong last marks");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && rsp_channel.token_kind == stt_pkg::KIND_EOF
      |-> rsp_channel.last_of_run)
      else $error("eof word not last of run");

   a_eof_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_channel.valid && rsp_channel.token_kind == stt_pkg::KIND_EOF
      |-> rsp_channel.value_length == '0)
      else $error("eof word with nonzero length");
`endif

endmodule
